// File: src/kcp_pkg.sv
// shared constants, types and helpers of the covariance predictor
package kcp_pkg;

    localparam int DIM       = 15;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int CELLS     = DIM * DIM;
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW        = (DIM > 1) ? $clog2(DIM) + 1 : 1;
    localparam int ACC_W     = 2 * DW + $clog2(DIM) + 1;

    localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [2:0] {
        FUNC_WR_P = 3'd0,
        FUNC_WR_F = 3'd1,
        FUNC_WR_Q = 3'd2,
        FUNC_COMP = 3'd3,
        FUNC_RD_P = 3'd4
    } func_t;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1,
        ST_D1,
        ST_P2,
        ST_D2,
        ST_S0,
        ST_S1,
        ST_S2,
        ST_RDW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic          phase2;
        logic [AW-1:0] addr;
    } mac_ctl_t;

    typedef struct packed {
        logic                 valid;
        logic                 ovf;
        logic [AW-1:0]        addr;
        logic signed [DW-1:0] data;
    } mac_res_t;

    function automatic logic [AW-1:0] cell_addr(input int r, input int c);
        return AW'(r * DIM + c);
    endfunction

endpackage

// File: src/kcp_ram.sv
// generic single write port ram with registered read
module kcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 225,
    localparam int AWR  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AWR-1:0]   waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AWR-1:0]   raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/kcp_mac.sv
// shared multiply-accumulate unit with scaling, noise add and saturation
module kcp_mac
    import kcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mac_ctl_t             ctl_in,
    input  logic signed [DW-1:0] a,
    input  logic signed [DW-1:0] b,
    input  logic signed [DW-1:0] q,
    output mac_res_t             res,
    output logic                 busy
);

    mac_ctl_t                ctl_m_reg, ctl_a_reg;
    logic signed [2*DW-1:0]  prod_reg;
    logic signed [DW-1:0]    q_m_reg, q_a_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    mac_res_t                res_reg, res_next;

    logic signed [ACC_W-1:0] sh;
    logic                    ovf1, ovf2;
    logic signed [DW-1:0]    m1, m2;
    logic signed [DW:0]      s2;

    always_comb begin
        acc_next = acc_reg;
        if (ctl_m_reg.valid) begin
            if (ctl_m_reg.first) begin
                acc_next = ACC_W'(prod_reg);
            end else begin
                acc_next = acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_comb begin
        sh   = acc_reg >>> FRAC_BITS;
        ovf1 = !((&sh[ACC_W-1:DW-1]) || !(|sh[ACC_W-1:DW-1]));
        m1   = ovf1 ? (sh[ACC_W-1] ? SAT_MIN : SAT_MAX) : sh[DW-1:0];
        s2   = {m1[DW-1], m1} + {q_a_reg[DW-1], q_a_reg};
        ovf2 = s2[DW] != s2[DW-1];
        m2   = ovf2 ? (s2[DW] ? SAT_MIN : SAT_MAX) : s2[DW-1:0];
        res_next.valid = ctl_a_reg.valid && ctl_a_reg.last;
        res_next.addr  = ctl_a_reg.addr;
        if (ctl_a_reg.phase2) begin
            res_next.data = m2;
            res_next.ovf  = ovf1 || ovf2;
        end else begin
            res_next.data = m1;
            res_next.ovf  = ovf1;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        q_m_reg  <= q;
        q_a_reg  <= q_m_reg;
        acc_reg  <= acc_next;
        if (!aresetn) begin
            ctl_m_reg <= '0;
            ctl_a_reg <= '0;
            res_reg   <= '0;
        end else begin
            ctl_m_reg <= ctl_in;
            ctl_a_reg <= ctl_m_reg;
            res_reg   <= res_next;
        end
    end

    assign res  = res_reg;
    assign busy = ctl_m_reg.valid || ctl_a_reg.valid || res_reg.valid;

    a_acc_follows_ctl: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_m_reg.valid |=> ctl_a_reg.valid)
        else $error("accumulate stage lost a word");
    a_res_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res_reg.valid |-> $past(ctl_a_reg.valid && ctl_a_reg.last))
        else $error("result without last term");
    a_first_then_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_m_reg.valid && ctl_m_reg.first) |=> (acc_reg == $past(ACC_W'(prod_reg))))
        else $error("accumulator not restarted");

endmodule

// File: src/kalman_covariance_predictor.sv
// kalman covariance predictor top level: stores, sequencer and result register
// element writes give no word; a read is registered in the store, then held in ST_RDW
// and moved to the output register in ST_OUT once the output is free
// compute: two product passes through the shared multiply-accumulate unit, then
// a symmetrize pass over every cell through the single sum store read port
// one item at a time; s_ready is high only while the sequencer is idle
// aresetn clears control and the overflow flag; matrix stores hold no reset
module kalman_covariance_predictor
    import kcp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_func,
    input  logic [3:0]           s_row,
    input  logic [3:0]           s_col,
    input  logic signed [31:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic signed [31:0]   m_value_res,
    output logic                 m_overflow
);

    state_t state_reg, state_next;
    logic [IW-1:0] o_reg, o_next, mi_reg, mi_next, n_reg, n_next;
    logic          ovf_reg, ovf_next;
    logic          inrange_reg, inrange_next;
    logic          kind_reg, kind_next;
    logic signed [DW-1:0] hold_reg, hold_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_kind_reg, m_kind_next;
    logic signed [DW-1:0] m_val_reg, m_val_next;
    logic          m_ovf_reg, m_ovf_next;
    mac_ctl_t      ctl_issue, ctl_d1_reg;

    logic          accept, inrange;
    logic [AW-1:0] in_addr;

    logic          p_we, f_we, q_we, t_we, r_we;
    logic [AW-1:0] p_wa, p_ra, f_ra, q_ra, t_ra, r_ra;
    logic [DW-1:0] p_wd, p_rd, f_rd, q_rd, t_rd, r_rd;
    logic signed [DW:0] sym;

    mac_res_t      res;
    logic          mac_busy;
    logic signed [DW-1:0] mac_a, mac_b;

    assign accept  = s_valid && s_ready;
    assign inrange = (32'(s_row) < DIM) && (32'(s_col) < DIM);
    assign in_addr = cell_addr(int'(s_row), int'(s_col));
    assign sym     = {hold_reg[DW-1], hold_reg} + {r_rd[DW-1], r_rd};

    kcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_cov (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
    kcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_trans (
        .aclk(aclk), .we(f_we), .waddr(in_addr), .wdata(s_value), .raddr(f_ra),
        .rdata(f_rd));
    kcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_noise (
        .aclk(aclk), .we(q_we), .waddr(in_addr), .wdata(s_value), .raddr(q_ra),
        .rdata(q_rd));
    kcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_prod (
        .aclk(aclk), .we(t_we), .waddr(res.addr), .wdata(res.data), .raddr(t_ra),
        .rdata(t_rd));
    kcp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_sum (
        .aclk(aclk), .we(r_we), .waddr(res.addr), .wdata(res.data), .raddr(r_ra),
        .rdata(r_rd));

    assign mac_a = ctl_d1_reg.phase2 ? signed'(t_rd) : signed'(f_rd);
    assign mac_b = ctl_d1_reg.phase2 ? signed'(f_rd) : signed'(p_rd);

    kcp_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(ctl_d1_reg), .a(mac_a), .b(mac_b),
        .q(signed'(q_rd)), .res(res), .busy(mac_busy));

    always_comb begin
        state_next   = state_reg;
        o_next       = o_reg;
        mi_next      = mi_reg;
        n_next       = n_reg;
        ovf_next     = ovf_reg;
        inrange_next = inrange_reg;
        kind_next    = kind_reg;
        hold_next    = hold_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_val_next   = m_val_reg;
        m_ovf_next   = m_ovf_reg;
        s_ready      = state_reg == ST_IDLE;
        ctl_issue    = '0;
        p_we = 1'b0;
        f_we = 1'b0;
        q_we = 1'b0;
        p_wa = in_addr;
        p_wd = s_value;
        p_ra = in_addr;
        f_ra = cell_addr(int'(o_reg), int'(n_reg));
        q_ra = cell_addr(int'(o_reg), int'(mi_reg));
        t_ra = cell_addr(int'(o_reg), int'(n_reg));
        r_ra = cell_addr(int'(o_reg), int'(mi_reg));
        t_we = res.valid && (state_reg == ST_P1 || state_reg == ST_D1);
        r_we = res.valid && (state_reg == ST_P2 || state_reg == ST_D2);
        if (res.valid && res.ovf) begin
            ovf_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    priority case (s_func)
                        FUNC_WR_P: p_we = inrange;
                        FUNC_WR_F: f_we = inrange;
                        FUNC_WR_Q: q_we = inrange;
                        FUNC_COMP: begin
                            ovf_next   = 1'b0;
                            o_next     = '0;
                            mi_next    = '0;
                            n_next     = '0;
                            state_next = ST_P1;
                        end
                        FUNC_RD_P: begin
                            inrange_next = inrange;
                            state_next   = ST_RDW;
                        end
                        default: ;
                    endcase
                end
            end
            ST_P1, ST_P2: begin
                ctl_issue.valid  = 1'b1;
                ctl_issue.first  = n_reg == '0;
                ctl_issue.last   = n_reg == IW'(DIM - 1);
                ctl_issue.phase2 = state_reg == ST_P2;
                ctl_issue.addr   = cell_addr(int'(o_reg), int'(mi_reg));
                if (state_reg == ST_P1) begin
                    f_ra = cell_addr(int'(o_reg), int'(n_reg));
                    p_ra = cell_addr(int'(n_reg), int'(mi_reg));
                end else begin
                    f_ra = cell_addr(int'(mi_reg), int'(n_reg));
                end
                n_next = n_reg + 1'b1;
                if (n_reg == IW'(DIM - 1)) begin
                    n_next  = '0;
                    mi_next = mi_reg + 1'b1;
                    if (mi_reg == IW'(DIM - 1)) begin
                        mi_next = '0;
                        o_next  = o_reg + 1'b1;
                        if (o_reg == IW'(DIM - 1)) begin
                            o_next     = '0;
                            state_next = (state_reg == ST_P1) ? ST_D1 : ST_D2;
                        end
                    end
                end
            end
            ST_D1: begin
                if (!ctl_d1_reg.valid && !mac_busy) begin
                    state_next = ST_P2;
                end
            end
            ST_D2: begin
                if (!ctl_d1_reg.valid && !mac_busy) begin
                    state_next = ST_S0;
                end
            end
            ST_S0: begin
                r_ra       = cell_addr(int'(o_reg), int'(mi_reg));
                state_next = ST_S1;
            end
            ST_S1: begin
                r_ra       = cell_addr(int'(mi_reg), int'(o_reg));
                hold_next  = signed'(r_rd);
                state_next = ST_S2;
            end
            ST_S2: begin
                p_we       = 1'b1;
                p_wa       = cell_addr(int'(o_reg), int'(mi_reg));
                p_wd       = sym[DW:1];
                state_next = ST_S0;
                mi_next    = mi_reg + 1'b1;
                if (mi_reg == IW'(DIM - 1)) begin
                    mi_next = '0;
                    o_next  = o_reg + 1'b1;
                    if (o_reg == IW'(DIM - 1)) begin
                        kind_next  = KIND_DONE;
                        hold_next  = '0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RDW: begin
                kind_next  = KIND_READ;
                hold_next  = inrange_reg ? signed'(p_rd) : '0;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    m_val_next   = hold_reg;
                    m_ovf_next   = ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        o_reg       <= o_next;
        mi_reg      <= mi_next;
        n_reg       <= n_next;
        inrange_reg <= inrange_next;
        kind_reg    <= kind_next;
        hold_reg    <= hold_next;
        m_kind_reg  <= m_kind_next;
        m_val_reg   <= m_val_next;
        m_ovf_reg   <= m_ovf_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            ctl_d1_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            ctl_d1_reg  <= ctl_issue;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_value_res = m_val_reg;
    assign m_overflow  = m_ovf_reg;

    a_res_in_mac_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> (state_reg == ST_P1 || state_reg == ST_D1 ||
                       state_reg == ST_P2 || state_reg == ST_D2))
        else $error("mac result outside product phases");
    a_ovf_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FUNC_COMP) |=> !ovf_reg)
        else $error("overflow flag not cleared at compute start");
    a_sym_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_S0) |-> (!mac_busy && !ctl_d1_reg.valid))
        else $error("mac still busy during symmetrize");

endmodule
